[rtl/core/mrfp_pkg.sv]
// Shared constants for the request frame parser: parse phase codes,
// status codes and the frame header characters. No dependencies.
`timescale 1ns / 1ps

package mrfp_pkg;

  // Parse phases (plain vector codes)
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_M     = 3'd1;
  localparam logic [2:0] PH_DIR   = 3'd2;
  localparam logic [2:0] PH_SIZE  = 3'd3;
  localparam logic [2:0] PH_CMD   = 3'd4;
  localparam logic [2:0] PH_DATA  = 3'd5;
  localparam logic [2:0] PH_CHECK = 3'd6;
  localparam logic [2:0] PH_EMIT  = 3'd7;

  // Result status codes
  localparam logic [2:0] ST_BUSY      = 3'd0;
  localparam logic [2:0] ST_OK        = 3'd1;
  localparam logic [2:0] ST_BAD_START = 3'd2;
  localparam logic [2:0] ST_BAD_M     = 3'd3;
  localparam logic [2:0] ST_BAD_DIR   = 3'd4;
  localparam logic [2:0] ST_BAD_SUM   = 3'd5;
  localparam logic [2:0] ST_OVERSIZE  = 3'd6;

  // Header characters
  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_M     = 8'h4D;  // 'M'
  localparam logic [7:0] CH_DIR   = 8'h3C;  // '<'

endpackage

[rtl/core/msp_request_frame_parser.sv]
// Request frame parser top level: header/size/command/payload/checksum
// sequencer around the payload store. Uses mrfp_pkg and mrfp_payload_ram.
`timescale 1ns / 1ps

//  channel | ports                                         | dir
//  --------+-----------------------------------------------+-----
//  in      | in_valid, in_stall, in_byte_in                | in
//  out     | out_valid, out_stall, out_status,             | out
//          | out_frame_command, out_frame_size,            |
//          | out_payload_valid, out_payload_index,         |
//          | out_payload_byte, out_last                    |
//
//  Every byte that does not finish a good frame with payload yields one beat.
//  A good frame with N payload bytes yields N beats; for each, the single
//  read port of the payload store is read, then the output register loaded.
//  Synchronous active-low reset returns the parser to idle; the store is not
//  cleared. in_stall is high while payload beats go out and whenever the
//  output register is full and stalled.

module msp_request_frame_parser
  import mrfp_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status,
  output logic [7:0] out_frame_command,
  output logic [6:0] out_frame_size,
  output logic       out_payload_valid,
  output logic [5:0] out_payload_index,
  output logic [7:0] out_payload_byte,
  output logic       out_last
);

  localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam logic [8:0] DEPTH9 = 9'(PAYLOAD_DEPTH);

  // Control state
  logic [2:0] phase_r, phase_nxt;
  logic       emit_rdy_r, emit_rdy_nxt;
  logic       out_valid_r, out_valid_nxt;
  // Frame state
  logic [7:0] expected_size_r, expected_size_nxt;
  logic [7:0] command_byte_r, command_byte_nxt;
  logic [6:0] received_count_r, received_count_nxt;
  logic [7:0] running_xor_r, running_xor_nxt;
  logic [7:0] emit_idx_r, emit_idx_nxt;
  // Output register
  logic [2:0] o_status_r;
  logic [7:0] o_cmd_r;
  logic [6:0] o_size_r;
  logic       o_pvalid_r;
  logic [5:0] o_pidx_r;
  logic [7:0] o_pbyte_r;
  logic       o_last_r;

  logic       ld_out;
  logic [2:0] ld_status;
  logic [7:0] ld_cmd;
  logic [6:0] ld_size;
  logic       ld_pvalid;
  logic [5:0] ld_pidx;
  logic [7:0] ld_pbyte;
  logic       ld_last;

  logic       in_acc, out_free;
  logic [6:0] count_inc;
  logic [8:0] idx_inc;
  logic [7:0] wr_addr_ext;
  logic       ram_we, ram_re;
  logic [7:0] ram_rdata;

  assign out_free = ~out_valid_r | ~out_stall;
  assign in_stall = (phase_r == PH_EMIT) | ~out_free;
  assign in_acc   = in_valid & ~in_stall;

  assign count_inc   = received_count_r + 7'd1;
  assign idx_inc     = {1'b0, emit_idx_r} + 9'd1;
  assign wr_addr_ext = {1'b0, received_count_r};

  // Store write while collecting payload; reads only happen while emitting,
  // so the two ports never touch the same entry in the same cycle.
  assign ram_we = in_acc & (phase_r == PH_DATA) & ({2'b0, received_count_r} < DEPTH9);
  assign ram_re = (phase_r == PH_EMIT) & ~emit_rdy_r;

  mrfp_payload_ram #(
    .DEPTH (PAYLOAD_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wr_addr_ext[AW-1:0]),
    .wr_data (in_byte_in),
    .rd_en   (ram_re),
    .rd_addr (emit_idx_r[AW-1:0]),
    .rd_data (ram_rdata)
  );

  // Parse sequencer
  always_comb begin
    phase_nxt          = phase_r;
    emit_rdy_nxt       = emit_rdy_r;
    expected_size_nxt  = expected_size_r;
    command_byte_nxt   = command_byte_r;
    received_count_nxt = received_count_r;
    running_xor_nxt    = running_xor_r;
    emit_idx_nxt       = emit_idx_r;
    ld_out    = 1'b0;
    ld_status = ST_BUSY;
    ld_cmd    = 8'd0;
    ld_size   = 7'd0;
    ld_pvalid = 1'b0;
    ld_pidx   = 6'd0;
    ld_pbyte  = 8'd0;
    ld_last   = 1'b1;

    if (phase_r == PH_EMIT) begin
      if (!emit_rdy_r) begin
        emit_rdy_nxt = 1'b1;
      end else if (out_free) begin
        ld_out    = 1'b1;
        ld_status = ST_OK;
        ld_cmd    = command_byte_r;
        ld_size   = expected_size_r[6:0];
        ld_pvalid = 1'b1;
        ld_pidx   = emit_idx_r[5:0];
        ld_pbyte  = ram_rdata;
        ld_last   = (idx_inc == {1'b0, expected_size_r});
        emit_rdy_nxt = 1'b0;
        emit_idx_nxt = idx_inc[7:0];
        if (ld_last) begin
          phase_nxt = PH_IDLE;
        end
      end
    end else if (in_acc) begin
      ld_out = 1'b1;
      case (phase_r)
        PH_M: begin
          if (in_byte_in != CH_M) begin
            phase_nxt = PH_IDLE;
            ld_status = ST_BAD_M;
          end else begin
            phase_nxt = PH_DIR;
          end
        end
        PH_DIR: begin
          if (in_byte_in != CH_DIR) begin
            phase_nxt = PH_IDLE;
            ld_status = ST_BAD_DIR;
          end else begin
            phase_nxt = PH_SIZE;
          end
        end
        PH_SIZE: begin
          expected_size_nxt = in_byte_in;
          running_xor_nxt   = in_byte_in;
          if ({1'b0, in_byte_in} > DEPTH9) begin
            phase_nxt = PH_IDLE;
            ld_status = ST_OVERSIZE;
          end else begin
            phase_nxt = PH_CMD;
          end
        end
        PH_CMD: begin
          command_byte_nxt   = in_byte_in;
          running_xor_nxt    = running_xor_r ^ in_byte_in;
          received_count_nxt = 7'd0;
          phase_nxt = (expected_size_r == 8'd0) ? PH_CHECK : PH_DATA;
        end
        PH_DATA: begin
          running_xor_nxt    = running_xor_r ^ in_byte_in;
          received_count_nxt = count_inc;
          if ({1'b0, count_inc} >= expected_size_r) begin
            phase_nxt = PH_CHECK;
          end
        end
        PH_CHECK: begin
          phase_nxt = PH_IDLE;
          if (running_xor_r != in_byte_in) begin
            ld_status = ST_BAD_SUM;
          end else if (expected_size_r == 8'd0) begin
            ld_status = ST_OK;
            ld_cmd    = command_byte_r;
          end else begin
            // good frame with payload: hand over to the emit sequence
            ld_out       = 1'b0;
            phase_nxt    = PH_EMIT;
            emit_idx_nxt = 8'd0;
            emit_rdy_nxt = 1'b0;
          end
        end
        default: begin
          if (in_byte_in != CH_START) begin
            phase_nxt = PH_IDLE;
            ld_status = ST_BAD_START;
          end else begin
            phase_nxt = PH_M;
          end
        end
      endcase
    end
  end

  assign out_valid_nxt = ld_out | (out_valid_r & out_stall);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_IDLE;
      emit_rdy_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      expected_size_r  <= 8'd0;
      command_byte_r   <= 8'd0;
      received_count_r <= 7'd0;
      running_xor_r    <= 8'd0;
      emit_idx_r       <= 8'd0;
    end else begin
      phase_r          <= phase_nxt;
      emit_rdy_r       <= emit_rdy_nxt;
      out_valid_r      <= out_valid_nxt;
      expected_size_r  <= expected_size_nxt;
      command_byte_r   <= command_byte_nxt;
      received_count_r <= received_count_nxt;
      running_xor_r    <= running_xor_nxt;
      emit_idx_r       <= emit_idx_nxt;
    end
  end

  // Output beat register
  always_ff @(posedge clk) begin
    if (ld_out) begin
      o_status_r <= ld_status;
      o_cmd_r    <= ld_cmd;
      o_size_r   <= ld_size;
      o_pvalid_r <= ld_pvalid;
      o_pidx_r   <= ld_pidx;
      o_pbyte_r  <= ld_pbyte;
      o_last_r   <= ld_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = o_status_r;
  assign out_frame_command = o_cmd_r;
  assign out_frame_size    = o_size_r;
  assign out_payload_valid = o_pvalid_r;
  assign out_payload_index = o_pidx_r;
  assign out_payload_byte  = o_pbyte_r;
  assign out_last          = o_last_r;

  // Input is held off for the whole payload emit sequence
  a_emit_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_EMIT) |-> in_stall)
    else $error("input accepted during payload emit");

  // Emit index never runs past the frame length
  a_emit_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_EMIT) |-> ({1'b0, emit_idx_r} < {1'b0, expected_size_r}))
    else $error("emit index beyond frame size");

  // Payload beats only carry frame ok status
  a_payload_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_pvalid_r) |-> (o_status_r == ST_OK))
    else $error("payload beat with non-ok status");

  // Any status other than frame ok ends its byte in a single beat
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (o_status_r != ST_OK)) |-> o_last_r)
    else $error("status beat without last");

  // A payload store read is always followed by a ready read data cycle
  a_read_then_ready: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |=> (phase_r == PH_EMIT) && emit_rdy_r)
    else $error("read data not marked ready");

endmodule

[rtl/core/mrfp_payload_ram.sv]
// Payload store of the request frame parser: one write port, one read port,
// registered read data. Depends on nothing else.
`timescale 1ns / 1ps

module mrfp_payload_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[tb/testbench.sv]
// Self-checking bench for msp_request_frame_parser: walks a directed table of bytes, then random
// frames, noise and broken headers. It checks each result beat against a local frame predictor or a
// hand-written status. Depends on mrfp_pkg and the parser RTL only.
`timescale 1ns / 1ps

module testbench;
  import mrfp_pkg::*;

  localparam int DEPTH       = 64;
  localparam int BYTE_TARGET = 360;
  localparam int CALM_FROM   = 300;   // no idling on either side after this many bytes
  localparam int PAUSE_AT    = 180;   // sender drains the parser once here
  localparam int STALL_LIMIT = 1000;  // cycles with no beat on either channel
  localparam int TAIL_CYCLES = 20;

  // one result beat
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] cmd;
    logic [6:0] size;
    logic       pvalid;
    logic [5:0] index;
    logic [7:0] data;
    logic       last;
  } beat_t;

  // directed table row: byte plus an optional hand-written status
  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    logic [2:0] st;
  } row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte_in;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] out_status;
  logic [7:0] out_frame_command;
  logic [6:0] out_frame_size;
  logic       out_payload_valid;
  logic [5:0] out_payload_index;
  logic [7:0] out_payload_byte;
  logic       out_last;

  msp_request_frame_parser #(.PAYLOAD_DEPTH(DEPTH)) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte_in        (in_byte_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_frame_command (out_frame_command),
    .out_frame_size    (out_frame_size),
    .out_payload_valid (out_payload_valid),
    .out_payload_index (out_payload_index),
    .out_payload_byte  (out_payload_byte),
    .out_last          (out_last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // predictor state
  logic [2:0] ph;
  logic [7:0] want_size;
  logic [7:0] frame_cmd;
  logic [6:0] rx_count;
  logic [7:0] sum;
  logic [7:0] shadow_store [DEPTH];

  beat_t step_beats [$];   // beats caused by the byte just accepted
  beat_t pending [$];      // beats still owed by the parser

  int  errors;
  int  sent;
  int  checked;
  int  frames_ok;
  int  largest;
  int  idle_cycles;
  bit  calm_tail;
  int  stall_left;

  function automatic beat_t status_beat(logic [2:0] st);
    beat_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  // Advance the parse by one byte and fill step_beats with what it emits.
  function automatic void predict_byte(input logic [7:0] b);
    beat_t r;
    int    n;
    step_beats.delete();
    case (ph)
      PH_M: begin
        if (b != CH_M) begin
          ph = PH_IDLE;
          step_beats.push_back(status_beat(ST_BAD_M));
        end else begin
          ph = PH_DIR;
          step_beats.push_back(status_beat(ST_BUSY));
        end
      end
      PH_DIR: begin
        if (b != CH_DIR) begin
          ph = PH_IDLE;
          step_beats.push_back(status_beat(ST_BAD_DIR));
        end else begin
          ph = PH_SIZE;
          step_beats.push_back(status_beat(ST_BUSY));
        end
      end
      PH_SIZE: begin
        want_size = b;
        sum = b;
        if (b > DEPTH) begin
          ph = PH_IDLE;
          step_beats.push_back(status_beat(ST_OVERSIZE));
        end else begin
          ph = PH_CMD;
          step_beats.push_back(status_beat(ST_BUSY));
        end
      end
      PH_CMD: begin
        frame_cmd = b;
        sum = sum ^ b;
        rx_count = '0;
        ph = (want_size == 8'd0) ? PH_CHECK : PH_DATA;
        step_beats.push_back(status_beat(ST_BUSY));
      end
      PH_DATA: begin
        if (rx_count < DEPTH) shadow_store[rx_count] = b;
        sum = sum ^ b;
        rx_count = rx_count + 7'd1;
        if (rx_count >= want_size) ph = PH_CHECK;
        step_beats.push_back(status_beat(ST_BUSY));
      end
      PH_CHECK: begin
        ph = PH_IDLE;
        if (sum != b) begin
          step_beats.push_back(status_beat(ST_BAD_SUM));
        end else begin
          n = (want_size > DEPTH) ? DEPTH : want_size;
          frames_ok++;
          if (n > largest) largest = n;
          r = status_beat(ST_OK);
          r.cmd = frame_cmd;
          if (n == 0) begin
            step_beats.push_back(r);
          end else begin
            for (int i = 0; i < n; i++) begin
              r.size = 7'(n);
              r.pvalid = 1'b1;
              r.index = 6'(i);
              r.data = shadow_store[i];
              r.last = (i + 1 == n);
              step_beats.push_back(r);
            end
          end
        end
      end
      default: begin
        // idle and any unused phase code
        if (b != CH_START) begin
          ph = PH_IDLE;
          step_beats.push_back(status_beat(ST_BAD_START));
        end else begin
          ph = PH_M;
          step_beats.push_back(status_beat(ST_BUSY));
        end
      end
    endcase
  endfunction

  // Offer one byte, hold it until taken, then book its expected beats.
  // Entered and left just after a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                           input logic [2:0] typed_st = ST_BUSY);
    int gap;
    if (!calm_tail && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_byte_in <= b;
    do @(posedge clk); while (in_stall);
    predict_byte(b);
    if (typed) pending.push_back(status_beat(typed_st));
    else foreach (step_beats[i]) pending.push_back(step_beats[i]);
    sent++;
    @(negedge clk);
  endtask

  // Full frame with a chosen size; a bad checksum on request.
  task automatic send_frame(input int size, input bit bad_sum);
    logic [7:0] cmd;
    logic [7:0] x;
    logic [7:0] d;
    cmd = 8'($urandom);
    x = 8'(size) ^ cmd;
    send_byte(CH_START);
    send_byte(CH_M);
    send_byte(CH_DIR);
    send_byte(8'(size));
    send_byte(cmd);
    for (int i = 0; i < size; i++) begin
      d = 8'($urandom);
      x = x ^ d;
      send_byte(d);
    end
    if (bad_sum) x = x ^ 8'($urandom_range(1, 255));
    send_byte(x);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t mismatch %s: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Result side: sample at the rising edge, compare with the oldest expectation.
  always @(posedge clk) begin : result_monitor
    beat_t got;
    beat_t want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        got = '{out_status, out_frame_command, out_frame_size, out_payload_valid,
                out_payload_index, out_payload_byte, out_last};
        if (pending.size() == 0) begin
          errors++;
          $display("%0t mismatch: beat with nothing expected, got %h", $time, got);
        end else begin
          want = pending.pop_front();
          checked++;
          check_field("status", want.status, got.status);
          check_field("frame_command", want.cmd, got.cmd);
          check_field("frame_size", want.size, got.size);
          check_field("payload_valid", want.pvalid, got.pvalid);
          check_field("payload_index", want.index, got.index);
          check_field("payload_byte", want.data, got.data);
          check_field("last", want.last, got.last);
        end
      end
    end
  end

  // Receiver stalls in random bursts; no new burst starts once the tail is calm.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("%0t timeout: no beat on either channel for %0d cycles", $time, STALL_LIMIT);
    $display("testbench: FAIL");
    $finish;
  end

  // Directed bytes: header errors, oversize, empty frame, bad checksum.
  row_t directed_rows [24] = '{
    '{8'h00, 1'b1, ST_BAD_START}, '{8'hFF, 1'b1, ST_BAD_START},
    '{CH_START, 1'b1, ST_BUSY}, '{8'h00, 1'b1, ST_BAD_M},
    '{CH_START, 1'b1, ST_BUSY}, '{CH_M, 1'b1, ST_BUSY}, '{8'hFF, 1'b1, ST_BAD_DIR},
    '{CH_START, 1'b1, ST_BUSY}, '{CH_M, 1'b1, ST_BUSY}, '{CH_DIR, 1'b1, ST_BUSY},
    '{8'd65, 1'b1, ST_OVERSIZE},
    // empty payload, command 0xFF, checksum 0xFF
    '{CH_START, 1'b1, ST_BUSY}, '{CH_M, 1'b1, ST_BUSY}, '{CH_DIR, 1'b1, ST_BUSY},
    '{8'h00, 1'b1, ST_BUSY}, '{8'hFF, 1'b1, ST_BUSY}, '{8'hFF, 1'b0, ST_BUSY},
    // one payload byte, checksum should be 0xDB
    '{CH_START, 1'b1, ST_BUSY}, '{CH_M, 1'b1, ST_BUSY}, '{CH_DIR, 1'b1, ST_BUSY},
    '{8'h01, 1'b1, ST_BUSY}, '{8'h80, 1'b1, ST_BUSY}, '{8'h5A, 1'b1, ST_BUSY},
    '{8'h00, 1'b1, ST_BAD_SUM}
  };

  initial begin : stimulus
    int         kind;
    int         size;
    bit         paused;
    bit         big_done;
    logic [7:0] b;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte_in = 8'h00;
    out_stall = 1'b0;
    stall_left = 0;
    idle_cycles = 0;
    errors = 0;
    sent = 0;
    checked = 0;
    frames_ok = 0;
    largest = 0;
    calm_tail = 1'b0;
    paused = 1'b0;
    big_done = 1'b0;
    ph = PH_IDLE;
    want_size = '0;
    frame_cmd = '0;
    rx_count = '0;
    sum = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_byte(directed_rows[i].b, directed_rows[i].typed, directed_rows[i].st);

    // random part: mostly well-formed frames, some noise, broken and oversize headers
    while (sent < BYTE_TARGET) begin
      if (sent >= CALM_FROM) calm_tail = 1'b1;
      if (!paused && sent >= PAUSE_AT) begin
        in_valid <= 1'b0;
        do @(negedge clk); while (pending.size() != 0);
        paused = 1'b1;
      end
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        if (!big_done) begin
          size = DEPTH;
          big_done = 1'b1;
        end else begin
          case ($urandom_range(0, 11))
            0: size = DEPTH;
            1: size = $urandom_range(9, DEPTH - 1);
            default: size = $urandom_range(0, 8);
          endcase
        end
        send_frame(size, $urandom_range(0, 5) == 0);
      end else if (kind == 7) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end else if (kind == 8) begin
        // header broken after '$' or after 'M'
        send_byte(CH_START);
        if ($urandom_range(0, 1) == 0) begin
          b = 8'($urandom);
          if (b == CH_M) b = b ^ 8'h01;
        end else begin
          send_byte(CH_M);
          b = 8'($urandom);
          if (b == CH_DIR) b = b ^ 8'h01;
        end
        send_byte(b);
      end else begin
        send_byte(CH_START);
        send_byte(CH_M);
        send_byte(CH_DIR);
        send_byte(($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(DEPTH + 1, 255)));
      end
    end

    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending.size() != 0) errors++;

    $display("testbench: %0d bytes sent, %0d beats checked, %0d good frames (largest %0d)",
             sent, checked, frames_ok, largest);
    $display("testbench: header, oversize, checksum and empty-payload cases with stalls; %0d errors",
             errors);
    if (errors == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule

[msp_request_frame_parser.f]
rtl/core/mrfp_pkg.sv
rtl/core/mrfp_payload_ram.sv
rtl/core/msp_request_frame_parser.sv
tb/testbench.sv
